### rtl/bpa_pkg.sv
// Shared constants, command and status codes, and state type of the buddy page allocator.
`default_nettype none

package bpa_pkg;

    localparam int unsigned MAX_ORDERS_DEF = 11;
    localparam int unsigned NUM_PAGES_DEF  = 4096;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned PAGE_W   = 12;
    localparam int unsigned ORDER_W  = 4;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned IN_W     = 24;
    localparam int unsigned OUT_W    = 16;

    // One memory line holds 64 bitmap bits of one order.
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned WORD_LOG = 6;

    localparam logic [COUNT_W-1:0] PAGE_COUNT_RST = COUNT_W'(4096);

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT,
        CMD_ALLOC,
        CMD_FREE,
        CMD_RESERVE
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BAD_ORDER,
        ST_NO_MEM,
        ST_BAD_RANGE,
        ST_NOT_FREE
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP,
        S_A_RD,
        S_A_CHK,
        S_F_RD,
        S_F_WR,
        S_R_RD,
        S_R_CHK,
        S_SP_RD,
        S_SP_WR,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

### rtl/bpa_init_word.sv
// Computes one bitmap line of the greedy initial carving of the managed page range.
`default_nettype none

module bpa_init_word #(
    parameter int unsigned MAX_ORDERS = bpa_pkg::MAX_ORDERS_DEF,
    parameter int unsigned NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF
) (
    input  wire logic [((MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1)-1:0] row,
    input  wire logic [(((NUM_PAGES + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W > 1) ?
                        $clog2((NUM_PAGES + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W) :
                        1)-1:0] word,
    input  wire logic [$clog2(NUM_PAGES + 1)-1:0] managed,
    output logic [bpa_pkg::WORD_W-1:0] line
);
    import bpa_pkg::*;

    localparam int unsigned KW  = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int unsigned WPO = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int unsigned WAW = (WPO > 1) ? $clog2(WPO) : 1;
    localparam int unsigned PW  = $clog2(NUM_PAGES + 1);
    localparam int unsigned LW  = ((PW > WAW + WORD_LOG) ? PW : WAW + WORD_LOG) + 1;
    localparam logic [KW-1:0] TOP = KW'(MAX_ORDERS - 1);

    always_comb
    begin
        logic [LW-1:0] count;
        logic [LW-1:0] base;
        logic [LW-1:0] lo;
        logic [LW-1:0] mshift;
        logic [LW-1:0] tgt;
        count  = LW'(managed) >> (MAX_ORDERS - 1);
        base   = LW'({word, {WORD_LOG{1'b0}}});
        lo     = count - base;
        mshift = LW'(managed) >> row;
        tgt    = mshift & ~LW'(1);
        line   = '0;
        if (row == TOP)
        begin
            // The top order takes as many whole blocks as fit, from page zero up.
            if (count > base)
            begin
                if (lo >= LW'(WORD_W))
                    line = '1;
                else
                    line = (WORD_W'(1) << lo[WORD_LOG-1:0]) - WORD_W'(1);
            end
        end
        else if (row < TOP)
        begin
            // A lower order holds at most one block, right after the larger ones.
            if (mshift[0] && ((tgt >> WORD_LOG) == LW'(word)))
                line = WORD_W'(1) << tgt[WORD_LOG-1:0];
        end
    end

endmodule

`default_nettype wire

### rtl/buddy_page_allocator_top.sv
// Buddy page allocator: command decode, per-order bitmap memory and its sequencer.
// After a command is accepted, allocate scans bitmap lines and then splits one level at a
// time, free visits one order after another, reserve tries orders and then splits, and the
// reply is then loaded; a command rejected at decode goes straight to loading its reply.
// Init sweeps every memory line once and then loads its reply.
// One command at a time; reset sweeps zeros before any transfer.
`default_nettype none

module buddy_page_allocator_top #(
    parameter int unsigned MAX_ORDERS = bpa_pkg::MAX_ORDERS_DEF,
    parameter int unsigned NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [bpa_pkg::COUNT_W-1:0]  cfg_wdata,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // command [1:0], page [13:2], order [17:14], zero [23:18]
    input  wire logic [bpa_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // status [2:0], block_page [14:3], zero [15]
    output logic [bpa_pkg::OUT_W-1:0]         m_axis_tdata
);
    import bpa_pkg::*;

    localparam int unsigned KW    = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int unsigned WPO   = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int unsigned WAW   = (WPO > 1) ? $clog2(WPO) : 1;
    localparam int unsigned PW    = $clog2(NUM_PAGES + 1);
    localparam int unsigned SW    = (PW > WAW + WORD_LOG) ? PW : WAW + WORD_LOG;
    localparam int unsigned AW    = KW + WAW;
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned CW0   = (PW > COUNT_W) ? PW : COUNT_W;
    localparam int unsigned CHK_W = ((CW0 > MAX_ORDERS) ? CW0 : MAX_ORDERS) + 1;
    localparam logic [KW-1:0] TOP       = KW'(MAX_ORDERS - 1);
    localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);

    function automatic logic [AW-1:0] map_addr(input logic [KW-1:0] k,
                                               input logic [PW-1:0] p);
        logic [SW-1:0] s;
        s = SW'(p) >> k;
        return {k, s[WORD_LOG +: WAW]};
    endfunction

    function automatic logic [WORD_LOG-1:0] bit_pos(input logic [KW-1:0] k,
                                                    input logic [PW-1:0] p);
        logic [SW-1:0] s;
        s = SW'(p) >> k;
        return s[WORD_LOG-1:0];
    endfunction

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_re;
    logic              mem_we;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    state_t             state_reg, state_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [KW-1:0]      lim_reg, lim_next;
    logic [WAW-1:0]     w_reg, w_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [AW-1:0]      sweep_reg, sweep_next;
    logic               init_mode_reg, init_mode_next;
    cmd_t               cmd_reg, cmd_next;
    status_t            status_reg, status_next;
    logic [COUNT_W-1:0] page_count_reg;
    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [PAGE_W-1:0]  out_page_reg;
    logic               load_out;

    logic [CHK_W-1:0]   managed_w;
    logic [PW-1:0]      managed;
    logic [WORD_W-1:0]  init_line;

    cmd_t               in_cmd;
    logic [PAGE_W-1:0]  in_page;
    logic [ORDER_W-1:0] in_order;

    assign in_cmd   = cmd_t'(s_axis_tdata[1:0]);
    assign in_page  = s_axis_tdata[13:2];
    assign in_order = s_axis_tdata[17:14];

    assign managed_w = (CHK_W'(page_count_reg) > CHK_W'(NUM_PAGES)) ?
                       CHK_W'(NUM_PAGES) : CHK_W'(page_count_reg);
    assign managed   = managed_w[PW-1:0];

    bpa_init_word #(
        .MAX_ORDERS (MAX_ORDERS),
        .NUM_PAGES  (NUM_PAGES)
    ) u_init_word (
        .row     (sweep_reg[AW-1 -: KW]),
        .word    (sweep_reg[WAW-1:0]),
        .managed (managed),
        .line    (init_line)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        logic [AW-1:0]       line_addr;
        logic [WORD_LOG-1:0] pos;
        logic [WORD_LOG-1:0] bpos;
        logic [KW-1:0]       km1;
        logic [PW-1:0]       half;
        logic [PW-1:0]       sp;
        logic [AW-1:0]       sp_addr;
        logic [WORD_LOG-1:0] sp_pos;
        logic [WORD_W-1:0]   lsb;
        logic [WORD_LOG-1:0] idx;
        logic [WAW-1:0]      lastw;
        logic [AW-1:0]       last_addr;
        logic [CHK_W-1:0]    size;
        logic                ord_bad;

        line_addr = map_addr(k_reg, p_reg);
        pos       = bit_pos(k_reg, p_reg);
        bpos      = pos ^ WORD_LOG'(1);
        km1       = k_reg - KW'(1);
        half      = PW'(1) << km1;
        sp        = (p_reg & ~(half - PW'(1))) ^ half;
        sp_addr   = map_addr(km1, sp);
        sp_pos    = bit_pos(km1, sp);
        lsb       = rd_data_reg & (~rd_data_reg + WORD_W'(1));
        idx       = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (lsb[i])
                idx = idx | WORD_LOG'(i);
        end
        last_addr = map_addr(k_reg, LAST_PAGE);
        lastw     = last_addr[WAW-1:0];
        size      = CHK_W'(1) << in_order;
        ord_bad   = (32'(in_order) >= 32'(MAX_ORDERS));

        state_next     = state_reg;
        k_next         = k_reg;
        lim_next       = lim_reg;
        w_next         = w_reg;
        p_next         = p_reg;
        sweep_next     = sweep_reg;
        init_mode_next = init_mode_reg;
        cmd_next       = cmd_reg;
        status_next    = status_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = line_addr;
        wr_addr        = line_addr;
        wr_data        = rd_data_reg;
        s_axis_tready  = 1'b0;
        load_out       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd_next    = in_cmd;
                    status_next = ST_OK;
                    case (in_cmd)
                        CMD_INIT:
                        begin
                            init_mode_next = 1'b1;
                            sweep_next     = '0;
                            state_next     = S_SWEEP;
                        end
                        CMD_ALLOC:
                        begin
                            if (ord_bad)
                            begin
                                status_next = ST_BAD_ORDER;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                k_next     = KW'(in_order);
                                lim_next   = KW'(in_order);
                                w_next     = '0;
                                state_next = S_A_RD;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (ord_bad)
                            begin
                                status_next = ST_BAD_ORDER;
                                state_next  = S_DONE;
                            end
                            else if (((CHK_W'(in_page) & (size - CHK_W'(1))) != '0) ||
                                     (CHK_W'(in_page) + size > managed_w))
                            begin
                                status_next = ST_BAD_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                k_next     = KW'(in_order);
                                p_next     = PW'(in_page);
                                state_next = S_F_RD;
                            end
                        end
                        default:
                        begin
                            if (CHK_W'(in_page) >= managed_w)
                            begin
                                status_next = ST_BAD_RANGE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                k_next     = '0;
                                lim_next   = '0;
                                p_next     = PW'(in_page);
                                state_next = S_R_RD;
                            end
                        end
                    endcase
                end
            end

            S_SWEEP:
            begin
                mem_we  = 1'b1;
                wr_addr = sweep_reg;
                wr_data = init_mode_reg ? init_line : '0;
                if (sweep_reg == AW'(DEPTH - 1))
                    state_next = init_mode_reg ? S_DONE : S_IDLE;
                else
                    sweep_next = sweep_reg + AW'(1);
            end

            S_A_RD:
            begin
                mem_re     = 1'b1;
                rd_addr    = {k_reg, w_reg};
                state_next = S_A_CHK;
            end

            S_A_CHK:
            begin
                if (rd_data_reg != '0)
                begin
                    mem_we  = 1'b1;
                    wr_addr = {k_reg, w_reg};
                    wr_data = rd_data_reg & ~lsb;
                    p_next  = PW'(SW'({w_reg, idx}) << k_reg);
                    state_next = (k_reg > lim_reg) ? S_SP_RD : S_DONE;
                end
                else if (w_reg == lastw)
                begin
                    if (k_reg == TOP)
                    begin
                        status_next = ST_NO_MEM;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + KW'(1);
                        w_next     = '0;
                        state_next = S_A_RD;
                    end
                end
                else
                begin
                    w_next     = w_reg + WAW'(1);
                    state_next = S_A_RD;
                end
            end

            S_F_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_F_WR;
            end

            S_F_WR:
            begin
                mem_we = 1'b1;
                // Merge when the buddy is free and a higher order still exists.
                if ((k_reg != TOP) && rd_data_reg[bpos])
                begin
                    wr_data    = rd_data_reg & ~(WORD_W'(1) << pos) & ~(WORD_W'(1) << bpos);
                    p_next     = p_reg & ~(PW'(1) << k_reg);
                    k_next     = k_reg + KW'(1);
                    state_next = S_F_RD;
                end
                else
                begin
                    wr_data    = rd_data_reg | (WORD_W'(1) << pos);
                    state_next = S_DONE;
                end
            end

            S_R_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_R_CHK;
            end

            S_R_CHK:
            begin
                if (rd_data_reg[pos])
                begin
                    mem_we     = 1'b1;
                    wr_data    = rd_data_reg & ~(WORD_W'(1) << pos);
                    state_next = (k_reg != '0) ? S_SP_RD : S_DONE;
                end
                else if (k_reg == TOP)
                begin
                    status_next = ST_NOT_FREE;
                    state_next  = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_R_RD;
                end
            end

            S_SP_RD:
            begin
                // Free the half that does not hold the kept page, one order down.
                mem_re     = 1'b1;
                rd_addr    = sp_addr;
                state_next = S_SP_WR;
            end

            S_SP_WR:
            begin
                mem_we     = 1'b1;
                wr_addr    = sp_addr;
                wr_data    = rd_data_reg | (WORD_W'(1) << sp_pos);
                k_next     = km1;
                state_next = (km1 == lim_reg) ? S_DONE : S_SP_RD;
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_reg      <= '0;
            init_mode_reg  <= 1'b0;
            k_reg          <= '0;
            lim_reg        <= '0;
            w_reg          <= '0;
            cmd_reg        <= CMD_INIT;
            status_reg     <= ST_OK;
            page_count_reg <= PAGE_COUNT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            init_mode_reg <= init_mode_next;
            k_reg         <= k_next;
            lim_reg       <= lim_next;
            w_reg         <= w_next;
            cmd_reg       <= cmd_next;
            status_reg    <= status_next;
            if (cfg_we)
                page_count_reg <= cfg_wdata;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_page_reg   <= ((cmd_reg == CMD_ALLOC) && (status_reg == ST_OK)) ?
                              PAGE_W'(p_reg) : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_page_reg, out_status_reg};

`ifndef SYNTHESIS
    a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_re && mem_we))
        else $error("memory read and write issued in the same cycle");

    a_rmw_same_line: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_SWEEP) |-> ($past(mem_re) && wr_addr == $past(rd_addr)))
        else $error("write-back does not follow a read of the same line");

    a_order_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_SWEEP) |-> (k_reg <= TOP))
        else $error("order counter beyond the top order");
`endif

endmodule

`default_nettype wire
